FILE: rtl/core/pfc_pkg.sv
// Shared types, codes and constants of the pixel format converter.
`timescale 1ns / 1ps

package pfc_pkg;

  // Pixel format codes
  localparam logic [2:0] FMT_RGBA = 3'd0;
  localparam logic [2:0] FMT_BGRA = 3'd1;
  localparam logic [2:0] FMT_RGB  = 3'd2;
  localparam logic [2:0] FMT_BGR  = 3'd3;
  localparam logic [2:0] FMT_L    = 3'd4;
  localparam logic [2:0] FMT_LA   = 3'd5;

  // Component type codes
  localparam logic [2:0] TY_BYTE  = 3'd0;
  localparam logic [2:0] TY_8888  = 3'd1;
  localparam logic [2:0] TY_565   = 3'd2;
  localparam logic [2:0] TY_5551  = 3'd3;
  localparam logic [2:0] TY_1555R = 3'd4;
  localparam logic [2:0] TY_4444  = 3'd5;
  localparam logic [2:0] TY_4444R = 3'd6;

  // Register indexes on the config port
  localparam logic [2:0] REG_SRC_FMT = 3'd0;
  localparam logic [2:0] REG_SRC_TY  = 3'd1;
  localparam logic [2:0] REG_DST_FMT = 3'd2;
  localparam logic [2:0] REG_DST_TY  = 3'd3;

  // Luminance weights
  localparam logic [7:0] LUMA_R = 8'd77;
  localparam logic [7:0] LUMA_G = 8'd151;
  localparam logic [7:0] LUMA_B = 8'd28;

  // Result status
  typedef enum logic [1:0] {
    ST_CONVERTED   = 2'd0,
    ST_PASSED      = 2'd1,
    ST_UNSUPPORTED = 2'd2
  } status_e;

  // Conversion selected by the current configuration
  typedef enum logic [4:0] {
    OP_NONE,
    OP_PASS,
    OP_SWAP02,
    OP_REV4,
    OP_ROT1555,
    OP_L_TO_RGBA,
    OP_L_TO_RGB,
    OP_TO_LA,
    OP_TO_L,
    OP_BGR_TO_RGB,
    OP_BGR_TO_RGBA,
    OP_RGBA_TO_RGB,
    OP_PACK565,
    OP_PACK5551,
    OP_PACK4444,
    OP_UNPACK4444R,
    OP_UNPACK5551
  } op_e;

  // Decoded conversion control
  typedef struct packed {
    op_e        op;
    logic       bgr;       // red sits in byte 2, blue in byte 0
    logic [2:0] count;     // valid bytes in the result
    status_e    status;
  } mode_t;

  // Input word
  typedef struct packed {
    logic [31:0] pixel_in;
    logic        last_pixel;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [31:0] pixel_out;
    logic [2:0]  byte_count;
    logic [1:0]  status;
    logic        last_out;
  } out_word_t;

endpackage

FILE: rtl/core/pixel_format_converter_top.sv
// Top level of the pixel format converter: input and result registers.
`timescale 1ns / 1ps

// Pixel format converter.
// Input channel: in_valid_i / in_stall_o carry one source pixel word with
// its last marker. Output channel: out_valid_o / out_stall_i carry the
// converted pixel, its byte count, a status and the last marker.
// Config channel: cfg_valid_i / cfg_ready_o write one of four 3-bit
// registers (source format, source type, target format, target type);
// ready is always high. Write config only while no words are in flight.
// Each word passes the input register, conversion logic and the result
// register in that order. Throughput: one word per cycle while the receiver
// does not stall.
// Reset clears both stage valids and sets all config registers to zero
// (RGBA bytes to RGBA bytes, a pass-through).
// When the receiver stalls, the result register holds; the input register
// still takes one more word while it is empty, and in_stall_o rises only
// when both stages are full and the output is stalled.
module pixel_format_converter_top import pfc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [2:0] cfg_data_i
);

  mode_t     mode;
  in_word_t  in_q;
  out_word_t conv, out_q;
  logic      in_v_q, out_v_q;
  logic      out_en, in_en;

  pfc_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .mode_o      (mode)
  );

  pfc_convert u_convert (
    .mode_i (mode),
    .word_i (in_q),
    .word_o (conv)
  );

  // Stage enables
  assign out_en     = !out_v_q || !out_stall_i;
  assign in_en      = !in_v_q || out_en;
  assign in_stall_o = !in_en;

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_en)  in_v_q  <= in_valid_i;
      if (out_en) out_v_q <= in_v_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_en && in_valid_i) in_q <= in_word_i;
    if (out_en && in_v_q)    out_q <= conv;
  end

  assign out_valid_o = out_v_q;
  assign out_word_o  = out_q;

endmodule

FILE: rtl/core/pfc_decode.sv
// Config registers and decode of the format pair into a conversion mode.
`timescale 1ns / 1ps

module pfc_decode import pfc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [2:0] cfg_data_i,
  output mode_t      mode_o
);

  logic [2:0] src_fmt_q, src_ty_q, dst_fmt_q, dst_ty_q;

  assign cfg_ready_o = 1'b1;

  // Config registers; indexes past the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_fmt_q <= FMT_RGBA;
      src_ty_q  <= TY_BYTE;
      dst_fmt_q <= FMT_RGBA;
      dst_ty_q  <= TY_BYTE;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SRC_FMT: src_fmt_q <= cfg_data_i;
        REG_SRC_TY:  src_ty_q  <= cfg_data_i;
        REG_DST_FMT: dst_fmt_q <= cfg_data_i;
        REG_DST_TY:  dst_ty_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Bytes per pixel for a legal format and type
  function automatic logic [2:0] pix_size(logic [2:0] fmt, logic [2:0] ty);
    logic [2:0] sz;
    if (ty == TY_BYTE) begin
      case (fmt)
        FMT_RGBA, FMT_BGRA: sz = 3'd4;
        FMT_RGB, FMT_BGR:   sz = 3'd3;
        FMT_L:              sz = 3'd1;
        default:            sz = 3'd2;
      endcase
    end else if (ty == TY_8888) begin
      sz = 3'd4;
    end else begin
      sz = 3'd2;
    end
    return sz;
  endfunction

  // Pair decode, first match wins
  always_comb begin
    logic [2:0] sf, st, df, dt;
    logic       sb, db, s4, d4, legal;
    op_e        op;
    logic [2:0] cnt;
    sf = src_fmt_q;
    st = src_ty_q;
    df = dst_fmt_q;
    dt = dst_ty_q;
    sb = (st == TY_BYTE);
    db = (dt == TY_BYTE);
    s4 = (sf == FMT_RGBA) || (sf == FMT_BGRA);
    d4 = (df == FMT_RGBA) || (df == FMT_BGRA);
    legal = (sf <= FMT_LA) && (df <= FMT_LA) && (st <= TY_4444R) && (dt <= TY_4444R);
    cnt = 3'd0;
    op  = OP_NONE;

    if (!legal) begin
      op = OP_NONE;
    end else if (sf == df && st == dt) begin
      op = OP_PASS; cnt = pix_size(sf, st);
    end else if (s4 && d4 && sf != df && sb && db) begin
      op = OP_SWAP02; cnt = 3'd4;
    end else if (s4 && sf == df && ((sb && dt == TY_8888) || (st == TY_8888 && db))) begin
      op = OP_REV4; cnt = 3'd4;
    end else if (sf == FMT_BGRA && df == FMT_RGBA && st == TY_1555R && dt == TY_5551) begin
      op = OP_ROT1555; cnt = 3'd2;
    end else if (sf == FMT_L && sb && db && df == FMT_RGBA) begin
      op = OP_L_TO_RGBA; cnt = 3'd4;
    end else if (sf == FMT_L && sb && db && df == FMT_RGB) begin
      op = OP_L_TO_RGB; cnt = 3'd3;
    end else if (s4 && df == FMT_LA && sb && db) begin
      op = OP_TO_LA; cnt = 3'd2;
    end else if (sf <= FMT_BGR && df == FMT_L && sb && db) begin
      op = OP_TO_L; cnt = 3'd1;
    end else if ((sf == FMT_BGR || sf == FMT_BGRA) && df == FMT_RGB && sb && db) begin
      op = OP_BGR_TO_RGB; cnt = 3'd3;
    end else if (sf == FMT_BGR && df == FMT_RGBA && sb && db) begin
      op = OP_BGR_TO_RGBA; cnt = 3'd4;
    end else if (sf == FMT_RGBA && df == FMT_RGB && sb && db) begin
      op = OP_RGBA_TO_RGB; cnt = 3'd3;
    end else if (sf <= FMT_BGR && df == FMT_RGB && sb && dt == TY_565) begin
      op = OP_PACK565; cnt = 3'd2;
    end else if (s4 && df == FMT_RGBA && sb && dt == TY_5551) begin
      op = OP_PACK5551; cnt = 3'd2;
    end else if (s4 && df == FMT_RGBA && sb && dt == TY_4444) begin
      op = OP_PACK4444; cnt = 3'd2;
    end else if (sf == FMT_BGRA && df == FMT_RGBA && st == TY_4444R && db) begin
      op = OP_UNPACK4444R; cnt = 3'd4;
    end else if (sf == FMT_RGBA && df == FMT_RGBA && st == TY_5551 && db) begin
      op = OP_UNPACK5551; cnt = 3'd4;
    end

    mode_o.op     = op;
    mode_o.bgr    = (sf == FMT_BGRA) || (sf == FMT_BGR);
    mode_o.count  = cnt;
    mode_o.status = (op == OP_NONE) ? ST_UNSUPPORTED :
                    (op == OP_PASS) ? ST_PASSED : ST_CONVERTED;
  end

endmodule

FILE: rtl/core/pfc_convert.sv
// Per-pixel conversion datapath between the input and result registers.
`timescale 1ns / 1ps

module pfc_convert import pfc_pkg::*; (
  input  mode_t     mode_i,
  input  in_word_t  word_i,
  output out_word_t word_o
);

  logic [7:0]  b0, b1, b2, b3, r, g, b;
  logic [15:0] h, luma_sum;
  logic [7:0]  luma;
  logic [31:0] pass_mask, res;

  assign b0 = word_i.pixel_in[7:0];
  assign b1 = word_i.pixel_in[15:8];
  assign b2 = word_i.pixel_in[23:16];
  assign b3 = word_i.pixel_in[31:24];
  assign h  = word_i.pixel_in[15:0];

  // Red and blue positions follow the source order
  assign r = mode_i.bgr ? b2 : b0;
  assign g = b1;
  assign b = mode_i.bgr ? b0 : b2;

  // Weighted luminance, weights sum to 256 so the sum fits 16 bits
  assign luma_sum = 16'(r * LUMA_R) + 16'(g * LUMA_G) + 16'(b * LUMA_B);
  assign luma     = luma_sum[15:8];

  // Byte mask for pass-through
  always_comb begin
    case (mode_i.count)
      3'd1:    pass_mask = 32'h0000_00ff;
      3'd2:    pass_mask = 32'h0000_ffff;
      3'd3:    pass_mask = 32'h00ff_ffff;
      default: pass_mask = 32'hffff_ffff;
    endcase
  end

  // Result select
  always_comb begin
    case (mode_i.op)
      OP_PASS:        res = word_i.pixel_in & pass_mask;
      OP_SWAP02:      res = {b3, b0, b1, b2};
      OP_REV4:        res = {b0, b1, b2, b3};
      OP_ROT1555:     res = {16'd0, h[14:0], h[15]};
      OP_L_TO_RGBA:   res = {8'hff, b0, b0, b0};
      OP_L_TO_RGB:    res = {8'd0, b0, b0, b0};
      OP_TO_LA:       res = {16'd0, b3, luma};
      OP_TO_L:        res = {24'd0, luma};
      OP_BGR_TO_RGB:  res = {8'd0, b0, b1, b2};
      OP_BGR_TO_RGBA: res = {8'hff, b0, b1, b2};
      OP_RGBA_TO_RGB: res = {8'd0, b2, b1, b0};
      OP_PACK565:     res = {16'd0, r[7:3], g[7:2], b[7:3]};
      OP_PACK5551:    res = {16'd0, r[7:3], g[7:3], b[7:3], (b3 != 8'd0)};
      OP_PACK4444:    res = {16'd0, r[7:4], g[7:4], b[7:4], b3[7:4]};
      OP_UNPACK4444R: res = {h[15:12], 4'd0, h[3:0], 4'd0, h[7:4], 4'd0, h[11:8], 4'd0};
      OP_UNPACK5551:  res = {{8{h[0]}}, h[5:1], 3'd0, h[10:6], 3'd0, h[15:11], 3'd0};
      default:        res = 32'd0;
    endcase
  end

  assign word_o.pixel_out  = res;
  assign word_o.byte_count = mode_i.count;
  assign word_o.status     = mode_i.status;
  assign word_o.last_out   = word_i.last_pixel;

endmodule
